// ===== rtl/modular_arithmetic_unit_assert.svh =====
// Assertion macros for the modular arithmetic unit checker.
// Used by mau_checker; needs clk and rst in the scope of each use.
`ifndef MODULAR_ARITHMETIC_UNIT_ASSERT_SVH
`define MODULAR_ARITHMETIC_UNIT_ASSERT_SVH

// same-cycle implication
`define MAU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define MAU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/mau_pkg.sv =====
// Shared types and codes for the modular arithmetic unit.
// No dependencies.
package mau_pkg;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_INV = 3'd4;
  localparam logic [2:0] OP_POW = 3'd5;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_SHL
  } alu_mode_t;

  typedef struct packed {
    alu_mode_t mode;
    logic      cin;
  } alu_ctl_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV,
    S_MUL,
    S_RED_B,
    S_DISPATCH,
    S_INV_LOOP,
    S_INV_Q,
    S_INV_T,
    S_POW,
    S_POW_ACC,
    S_POW_SQR,
    S_FIN_MUL,
    S_OUT
  } state_t;

endpackage

// ===== rtl/mau_alu.sv =====
// Shared modular add / subtract / shift-subtract unit.
// Depends on mau_pkg.
module mau_alu #(
  parameter int W = 32
) (
  input  mau_pkg::alu_ctl_t ctl,
  input  logic [W-1:0]      x,
  input  logic [W-1:0]      y,
  input  logic [W-1:0]      d,
  output logic [W-1:0]      res,
  output logic              ge
);
  import mau_pkg::*;

  logic [W:0] s;
  logic [W:0] diff;

  always_comb begin
    s    = '0;
    diff = {1'b0, x} - {1'b0, y};
    res  = '0;
    ge   = 1'b0;
    case (ctl.mode)
      ALU_ADD, ALU_SHL: begin
        if (ctl.mode == ALU_ADD) begin
          s = {1'b0, x} + {1'b0, y};
        end else begin
          s = {x, ctl.cin};
        end
        // both operands below d, so one subtract brings it into range
        ge  = (s >= {1'b0, d});
        res = ge ? W'(s - {1'b0, d}) : s[W-1:0];
      end
      ALU_SUB: begin
        res = diff[W] ? W'(diff[W-1:0] + d) : diff[W-1:0];
      end
      default: begin
        res = '0;
      end
    endcase
  end

endmodule

// ===== rtl/mau_seq.sv =====
// Sequencer and working registers; drives the shared ALU for every arithmetic step.
// Depends on mau_pkg and mau_alu.
module mau_seq #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [2:0]   in_op,
  input  logic [W-1:0] in_a,
  input  logic [W-1:0] in_b,
  input  logic [W-1:0] meff,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [W-1:0] out_res,
  output logic         out_flag
);
  import mau_pkg::*;

  localparam int CW = $clog2(W);

  state_t state, state_next, ret, ret_next;
  logic [CW-1:0] cnt, cnt_next;
  logic ph, ph_next;
  logic [2:0] op, op_next;
  logic [W-1:0] a, a_next, e, e_next, rem, rem_next, quo, quo_next;
  logic [W-1:0] dvd, dvd_next, dvs, dvs_next;
  logic [W-1:0] mx, mx_next, my, my_next, macc, macc_next;
  logic [W-1:0] r0, r0_next, r1, r1_next, t0, t0_next, t1, t1_next;
  logic [W-1:0] acc, acc_next, res, res_next;
  logic flag, flag_next;

  alu_ctl_t ctl;
  logic [W-1:0] alu_x, alu_y, alu_d, alu_res, qmod, one_m;
  logic alu_ge;

  mau_alu #(.W(W)) u_alu (
    .ctl(ctl), .x(alu_x), .y(alu_y), .d(alu_d), .res(alu_res), .ge(alu_ge)
  );

  assign qmod  = (quo == meff) ? '0 : quo;
  assign one_m = (meff == W'(1)) ? '0 : W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ret   <= S_IDLE;
    end else begin
      state <= state_next;
      ret   <= ret_next;
    end
  end

  always_ff @(posedge clk) begin
    cnt <= cnt_next;  ph <= ph_next;  op <= op_next;
    a <= a_next;  e <= e_next;  rem <= rem_next;  quo <= quo_next;
    dvd <= dvd_next;  dvs <= dvs_next;
    mx <= mx_next;  my <= my_next;  macc <= macc_next;
    r0 <= r0_next;  r1 <= r1_next;  t0 <= t0_next;  t1 <= t1_next;
    acc <= acc_next;  res <= res_next;  flag <= flag_next;
  end

  always_comb begin
    state_next = state;  ret_next = ret;
    cnt_next = cnt;  ph_next = ph;  op_next = op;
    a_next = a;  e_next = e;  rem_next = rem;  quo_next = quo;
    dvd_next = dvd;  dvs_next = dvs;
    mx_next = mx;  my_next = my;  macc_next = macc;
    r0_next = r0;  r1_next = r1;  t0_next = t0;  t1_next = t1;
    acc_next = acc;  res_next = res;  flag_next = flag;
    ctl.mode = ALU_ADD;  ctl.cin = 1'b0;
    alu_x = macc;  alu_y = macc;  alu_d = meff;
    in_ready = 1'b0;  out_valid = 1'b0;

    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op_next = in_op;  e_next = in_b;  flag_next = 1'b0;
          dvd_next = in_a;  dvs_next = meff;  rem_next = '0;
          cnt_next = CW'(W-1);  ret_next = S_RED_B;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        // restoring division, one quotient bit a cycle
        ctl.mode = ALU_SHL;  ctl.cin = dvd[W-1];
        alu_x = rem;  alu_d = dvs;
        rem_next = alu_res;
        quo_next = {quo[W-2:0], alu_ge};
        dvd_next = {dvd[W-2:0], 1'b0};
        if (cnt == '0) state_next = ret;
        else cnt_next = cnt - CW'(1);
      end
      S_MUL: begin
        // MSB-first double-and-add
        if (!ph) begin
          alu_x = macc;  alu_y = macc;
          macc_next = alu_res;
        end else begin
          alu_x = macc;  alu_y = mx;
          macc_next = alu_res;
        end
        if (!ph && my[W-1]) begin
          ph_next = 1'b1;
        end else begin
          ph_next = 1'b0;
          my_next = {my[W-2:0], 1'b0};
          if (cnt == '0) state_next = ret;
          else cnt_next = cnt - CW'(1);
        end
      end
      S_RED_B: begin
        a_next = rem;  dvd_next = e;  dvs_next = meff;  rem_next = '0;
        cnt_next = CW'(W-1);  ret_next = S_DISPATCH;
        state_next = S_DIV;
      end
      S_DISPATCH: begin
        alu_x = a;  alu_y = rem;
        r0_next = meff;  t0_next = '0;  t1_next = one_m;
        macc_next = '0;  cnt_next = CW'(W-1);  ph_next = 1'b0;
        case (op)
          OP_ADD: begin
            ctl.mode = ALU_ADD;  res_next = alu_res;  state_next = S_OUT;
          end
          OP_SUB: begin
            ctl.mode = ALU_SUB;  res_next = alu_res;  state_next = S_OUT;
          end
          OP_MUL: begin
            mx_next = a;  my_next = rem;  ret_next = S_FIN_MUL;
            state_next = S_MUL;
          end
          OP_DIV: begin
            r1_next = rem;  state_next = S_INV_LOOP;
          end
          OP_INV: begin
            r1_next = a;  state_next = S_INV_LOOP;
          end
          OP_POW: begin
            acc_next = one_m;  state_next = S_POW;
          end
          default: begin
            res_next = '0;  state_next = S_OUT;
          end
        endcase
      end
      S_INV_LOOP: begin
        if (r1 == '0) begin
          if (r0 == W'(1)) begin
            if (op == OP_DIV) begin
              mx_next = a;  my_next = t0;  macc_next = '0;
              cnt_next = CW'(W-1);  ph_next = 1'b0;
              ret_next = S_FIN_MUL;  state_next = S_MUL;
            end else begin
              res_next = t0;  state_next = S_OUT;
            end
          end else begin
            res_next = '0;  flag_next = 1'b1;  state_next = S_OUT;
          end
        end else begin
          dvd_next = r0;  dvs_next = r1;  rem_next = '0;
          cnt_next = CW'(W-1);  ret_next = S_INV_Q;
          state_next = S_DIV;
        end
      end
      S_INV_Q: begin
        r0_next = r1;  r1_next = rem;
        mx_next = qmod;  my_next = t1;  macc_next = '0;
        cnt_next = CW'(W-1);  ph_next = 1'b0;
        ret_next = S_INV_T;  state_next = S_MUL;
      end
      S_INV_T: begin
        ctl.mode = ALU_SUB;  alu_x = t0;  alu_y = macc;
        t1_next = alu_res;  t0_next = t1;
        state_next = S_INV_LOOP;
      end
      S_POW: begin
        macc_next = '0;  cnt_next = CW'(W-1);  ph_next = 1'b0;
        if (e == '0) begin
          res_next = acc;  state_next = S_OUT;
        end else if (e[0]) begin
          mx_next = acc;  my_next = a;
          ret_next = S_POW_ACC;  state_next = S_MUL;
        end else begin
          mx_next = a;  my_next = a;
          ret_next = S_POW_SQR;  state_next = S_MUL;
        end
      end
      S_POW_ACC: begin
        acc_next = macc;
        mx_next = a;  my_next = a;  macc_next = '0;
        cnt_next = CW'(W-1);  ph_next = 1'b0;
        ret_next = S_POW_SQR;  state_next = S_MUL;
      end
      S_POW_SQR: begin
        a_next = macc;  e_next = {1'b0, e[W-1:1]};
        state_next = S_POW;
      end
      S_FIN_MUL: begin
        res_next = macc;  state_next = S_OUT;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign out_res  = res;
  assign out_flag = flag;

endmodule

// ===== rtl/modular_arithmetic_unit.sv =====
// Modular arithmetic unit: add, subtract, multiply, divide, inverse and power
// under a programmable modulus. One input beat is taken at a time, and the next
// is accepted only after the result beat has gone. All work runs through one
// shared WIDTH-bit modular add/subtract/shift-subtract unit, one operation per
// cycle. Operands are first reduced by division, and a modular multiply runs
// double-and-add. Inverse and divide run extended Euclid, each step a division
// plus a multiply, for up to about 1.44*WIDTH steps. Power runs one or two
// multiplies per exponent bit up to its top set bit. A modulus of zero acts as
// one. Depends on mau_pkg, mau_seq and mau_alu.
module modular_arithmetic_unit #(
  parameter int WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        modulus_we,
  input  logic [31:0] modulus_wdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [2:0] operation, [34:3] operand_a, [66:35] operand_b, [71:67] zero
  input  logic [71:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [31:0] result
  output logic [31:0] m_axis_tdata,
  // [0] no_inverse
  output logic        m_axis_tuser
);
  import mau_pkg::*;

  logic [31:0] modulus;
  logic [63:0] mod_ext, a_ext, b_ext, res_ext;
  logic [WIDTH-1:0] mod_w, meff, a_w, b_w, res_w;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= 32'd1;
    end else if (modulus_we) begin
      modulus <= modulus_wdata;
    end
  end

  assign mod_ext = {32'd0, modulus};
  assign a_ext   = {32'd0, s_axis_tdata[34:3]};
  assign b_ext   = {32'd0, s_axis_tdata[66:35]};
  assign mod_w   = mod_ext[WIDTH-1:0];
  assign meff    = (mod_w == '0) ? WIDTH'(1) : mod_w;
  assign a_w     = a_ext[WIDTH-1:0];
  assign b_w     = b_ext[WIDTH-1:0];

  mau_seq #(.W(WIDTH)) u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_op    (s_axis_tdata[2:0]),
    .in_a     (a_w),
    .in_b     (b_w),
    .meff     (meff),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .out_res  (res_w),
    .out_flag (m_axis_tuser)
  );

  assign res_ext      = 64'(res_w);
  assign m_axis_tdata = res_ext[31:0];

endmodule

// ===== rtl/mau_checker.sv =====
// Port-level checks for the modular arithmetic unit, bound to the top level.
// Depends on modular_arithmetic_unit_assert.svh.
`include "modular_arithmetic_unit_assert.svh"

module mau_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  `MAU_ASSERT_NOW(a_one_at_a_time, m_axis_tvalid, !s_axis_tready, "ready while result pending")
  `MAU_ASSERT_NEXT(a_busy_after_in, s_axis_tvalid && s_axis_tready, !s_axis_tready && !m_axis_tvalid, "not busy after input beat")
  `MAU_ASSERT_NOW(a_noinv_zero, m_axis_tvalid && m_axis_tuser, m_axis_tdata == 32'd0, "no_inverse with nonzero result")
  `MAU_ASSERT_NEXT(a_idle_after_out, m_axis_tvalid && m_axis_tready, s_axis_tready && !m_axis_tvalid, "not idle after result beat")
  `MAU_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

endmodule

bind modular_arithmetic_unit mau_checker u_mau_checker (
  .clk          (clk),
  .rst          (rst),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);

// ===== bench/testbench.sv =====
// Testbench for modular_arithmetic_unit: directed table then random beats,
// each result checked against a behavioural predictor. Needs mau_pkg and the RTL.
`timescale 1ns / 1ps

module testbench;
  import mau_pkg::*;

  localparam int    N_RANDOM  = 265;
  localparam int    MAX_CYCLE = 20000000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        modulus_we = 1'b0;
  logic [31:0] modulus_wdata = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tuser;

  typedef struct packed {
    logic [31:0] result;
    logic        no_inv;
  } mod_result_t;

  typedef struct {
    logic [2:0]  op;
    logic [31:0] a;
    logic [31:0] b;
    logic        known;
    mod_result_t res;
  } vec_t;

  mod_result_t expected_q[$];
  logic [63:0] modulus_now = 64'd1;
  int          n_errors = 0;
  int          n_results = 0;
  int          cycle = 0;
  bit          calm = 1'b0;
  int          ready_hold = 0;

  always #10 clk = ~clk;

  modular_arithmetic_unit u_top (
    .clk(clk), .rst(rst),
    .modulus_we(modulus_we), .modulus_wdata(modulus_wdata),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  function automatic logic [63:0] mulmod(logic [63:0] x, logic [63:0] y, logic [63:0] m);
    logic [127:0] p;
    p = x * y;
    return 64'(p % m);
  endfunction

  function automatic logic [63:0] powmod(logic [63:0] base, logic [63:0] e, logic [63:0] m);
    logic [63:0] acc;
    acc = 64'd1 % m;
    while (e != 0) begin
      if (e[0]) acc = mulmod(acc, base, m);
      base = mulmod(base, base, m);
      e = e >> 1;
    end
    return acc;
  endfunction

  // extended Euclid with the coefficient kept reduced
  function automatic bit invmod(logic [63:0] x, logic [63:0] m, output logic [63:0] inv);
    logic [63:0] r0, r1, r2, t0, t1, t2, q;
    r0 = m; r1 = x; t0 = 0; t1 = 64'd1 % m;
    while (r1 != 0) begin
      q  = r0 / r1;
      r2 = r0 - q * r1;
      t2 = (t0 + m - mulmod(q % m, t1, m)) % m;
      r0 = r1; r1 = r2; t0 = t1; t1 = t2;
    end
    inv = (r0 == 1) ? t0 : 64'd0;
    return r0 == 1;
  endfunction

  function automatic mod_result_t modular_result(logic [2:0] op, logic [31:0] a_in,
                                                 logic [31:0] b_in);
    logic [63:0] m, a, b, iv;
    mod_result_t r;
    m = (modulus_now == 0) ? 64'd1 : modulus_now;
    a = a_in % m;
    b = b_in;
    r = '0;
    case (op)
      OP_ADD: r.result = 32'((a + b % m) % m);
      OP_SUB: r.result = 32'((a + m - b % m) % m);
      OP_MUL: r.result = 32'(mulmod(a, b % m, m));
      OP_DIV: begin
        if (invmod(b % m, m, iv)) r.result = 32'(mulmod(a, iv, m));
        else r.no_inv = 1'b1;
      end
      OP_INV: begin
        if (invmod(a, m, iv)) r.result = 32'(iv);
        else r.no_inv = 1'b1;
      end
      OP_POW: r.result = 32'(powmod(a, b, m));
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("[%0t] mismatch %s: got %h want %h", $time, what, got, want);
    n_errors++;
  endtask

  // result side: random stalls, checks each beat
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        n_results <= n_results + 1;
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected beat", m_axis_tdata, '0);
        end else begin
          mod_result_t e;
          e = expected_q.pop_front();
          if (m_axis_tdata !== e.result) report_mismatch("result", m_axis_tdata, e.result);
          if (m_axis_tuser !== e.no_inv)
            report_mismatch("no_inverse", 32'(m_axis_tuser), 32'(e.no_inv));
        end
      end
      if (ready_hold > 0) begin
        ready_hold <= ready_hold - 1;
        m_axis_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        ready_hold <= $urandom_range(0, 12);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (cycle >= MAX_CYCLE) begin
      $display("timeout after %0d cycles", cycle);
      $display("FAIL modular_arithmetic_unit");
      $finish;
    end
  end

  // valid drops only on an idle gap or a drain, so back-to-back beats update it once
  task automatic send(logic [2:0] op, logic [31:0] a, logic [31:0] b);
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    s_axis_tdata  <= {5'd0, b, a, op};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    expected_q.push_back(modular_result(op, a, b));
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_modulus(logic [31:0] m);
    drain();
    modulus_wdata <= m;
    modulus_we    <= 1'b1;
    @(posedge clk);
    modulus_we    <= 1'b0;
    modulus_now = m;
  endtask

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(0, 15);
      default: return $urandom;
    endcase
  endfunction

  vec_t table_v[] = '{
    // modulus 1 after reset: all zero
    '{OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{32'd0, 1'b0}},
    '{OP_INV, 32'd5,         32'd0,         1'b1, '{32'd0, 1'b0}},
    '{OP_POW, 32'd7,         32'd0,         1'b1, '{32'd0, 1'b0}},
    '{3'd6,   32'd1,         32'd2,         1'b1, '{32'd0, 1'b0}},
    // modulus 13 from here
    '{OP_ADD, 32'd12,        32'd12,        1'b1, '{32'd11, 1'b0}},
    '{OP_SUB, 32'd0,         32'd1,         1'b1, '{32'd12, 1'b0}},
    '{OP_MUL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '{32'd0, 1'b0}},
    '{OP_DIV, 32'd5,         32'd26,        1'b1, '{32'd0, 1'b1}},
    '{OP_DIV, 32'd6,         32'd3,         1'b1, '{32'd2, 1'b0}},
    '{OP_INV, 32'd0,         32'd9,         1'b1, '{32'd0, 1'b1}},
    '{OP_INV, 32'd2,         32'd0,         1'b1, '{32'd7, 1'b0}},
    '{OP_POW, 32'd2,         32'd0,         1'b1, '{32'd1, 1'b0}},
    '{OP_POW, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '{32'd0, 1'b0}},
    '{3'd7,   32'd4,         32'd4,         1'b1, '{32'd0, 1'b0}},
    // all-ones modulus from here
    '{OP_ADD, 32'hFFFF_FFFE, 32'hFFFF_FFFE, 1'b0, '{32'd0, 1'b0}},
    '{OP_SUB, 32'd0,         32'hFFFF_FFFE, 1'b0, '{32'd0, 1'b0}},
    '{OP_MUL, 32'hFFFF_FFFE, 32'hFFFF_FFFE, 1'b0, '{32'd0, 1'b0}},
    '{OP_DIV, 32'd7,         32'd3,         1'b0, '{32'd0, 1'b0}},
    '{OP_INV, 32'd2,         32'd0,         1'b0, '{32'd0, 1'b0}},
    '{OP_POW, 32'd3,         32'hFFFF_FFFF, 1'b0, '{32'd0, 1'b0}}
  };

  initial begin : stimulus
    int i;
    mod_result_t got_exp;
    logic [31:0] mods[6];
    mods = '{32'd0, 32'd2, 32'd97, 32'd65536, 32'hFFFF_FFFB, 32'hFFFF_FFFF};
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (i = 0; i < table_v.size(); i++) begin
      if (i == 4) set_modulus(32'd13);
      if (i == 14) set_modulus(32'hFFFF_FFFF);
      got_exp = modular_result(table_v[i].op, table_v[i].a, table_v[i].b);
      if (table_v[i].known && got_exp !== table_v[i].res)
        report_mismatch("table row", got_exp.result, table_v[i].res.result);
      send(table_v[i].op, table_v[i].a, table_v[i].b);
    end
    // random phases over several moduli, power exponents mostly short
    for (i = 0; i < N_RANDOM; i++) begin
      logic [2:0]  op;
      logic [31:0] b;
      if (i % 40 == 0) set_modulus((i / 40) < 6 ? mods[i / 40] : $urandom);
      if (i == 200) drain();  // sender waits for every result
      if (i == N_RANDOM - 30) calm = 1'b1;
      op = $urandom_range(0, 9) == 0 ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
      b  = rand_operand();
      if (op == OP_POW && $urandom_range(0, 3) != 0) b = $urandom_range(0, 255);
      send(op, rand_operand(), b);
    end
    drain();
    $display("covered %0d results over 9 modulus settings incl. 0, 1 and all-ones",
             n_results);
    $display("all six operations, unused codes, no-inverse cases, zero exponents");
    if (n_errors == 0) begin
      $display("PASS modular_arithmetic_unit");
    end else begin
      $display("FAIL modular_arithmetic_unit");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/mau_pkg.sv
rtl/mau_alu.sv
rtl/mau_seq.sv
rtl/modular_arithmetic_unit.sv
rtl/mau_checker.sv
bench/testbench.sv
